[src/transport_server_conn_table_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the connection table
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TRANSPORT_SERVER_CONN_TABLE_ASSERT_SVH
`define TRANSPORT_SERVER_CONN_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSCT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSCT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/tsct_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Connection table package
// Types, codes and sizes shared by the connection table modules.
// ----------------------------------------------------------------------------
package tsct_pkg;

   localparam int ENTRIES_DEF = 8;
   localparam int SOCK_W      = 3;
   localparam int PORT_W      = 16;

   // Item kinds.
   localparam logic [1:0] KIND_OPEN    = 2'd0;
   localparam logic [1:0] KIND_LISTEN  = 2'd1;
   localparam logic [1:0] KIND_CLOSE   = 2'd2;
   localparam logic [1:0] KIND_SEGMENT = 2'd3;

   // Result status codes.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_BAD_SOCK = 2'd2;
   localparam logic [1:0] STAT_NO_MATCH = 2'd3;

   // Connection states.
   localparam logic [1:0] CONN_CLOSED     = 2'd0;
   localparam logic [1:0] CONN_LISTEN     = 2'd1;
   localparam logic [1:0] CONN_ESTAB      = 2'd2;
   localparam logic [1:0] CONN_CLOSE_WAIT = 2'd3;

   // Segment types of interest.
   localparam logic [2:0] SEG_SYN = 3'd0;
   localparam logic [2:0] SEG_FIN = 3'd2;

   // Reply types.
   localparam logic REPLY_SYNACK = 1'b0;
   localparam logic REPLY_FINACK = 1'b1;

   typedef struct packed {
      logic [1:0]        kind;
      logic [SOCK_W-1:0] socket_id;
      logic [PORT_W-1:0] open_port;
      logic [2:0]        seg_type;
      logic [PORT_W-1:0] seg_src_port;
      logic [PORT_W-1:0] seg_dest_port;
   } req_type;

   typedef struct packed {
      logic [SOCK_W-1:0] result_socket;
      logic [1:0]        status;
      logic              reply_valid;
      logic              reply_type;
      logic [PORT_W-1:0] reply_src_port;
      logic [PORT_W-1:0] reply_dest_port;
      logic [1:0]        entry_state;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic look;
      logic exec;
   } cmd_type;

endpackage
`default_nettype wire

[src/tsct_ctl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Connection table controller
// Sequences accept, lookup and execute, and owns the result word's valid.
// ----------------------------------------------------------------------------
module tsct_ctl import tsct_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output cmd_type   cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.load = (state_ff == S_IDLE) && req_valid;
      cmd.look = (state_ff == S_LOOK);
      cmd.exec = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // The result register frees up when taken, and reloads on execute.
   assign rsp_valid_in = cmd.exec | (rsp_valid_ff & rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_LOOK;
         end
         S_LOOK: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (cmd.exec) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

[src/tsct_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Connection table datapath
// Holds the entry table, searches it and applies one item per command.
// ----------------------------------------------------------------------------
module tsct_dp import tsct_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire req_type req_data,
   output rsp_type      rsp_data
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int WIDE_W = 7;

   req_type           item_ff;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [PORT_W-1:0] server_ff [ENTRIES];
   logic [PORT_W-1:0] peer_ff   [ENTRIES];
   logic [1:0]        conn_ff   [ENTRIES];

   // Lookup results, registered between the lookup and execute steps.
   logic              free_hit_ff, match_hit_ff, sid_ok_ff;
   logic [IDX_W-1:0]  free_idx_ff, match_idx_ff;
   logic [PORT_W-1:0] server_rd_ff, peer_rd_ff;
   logic [1:0]        conn_rd_ff;
   rsp_type           rsp_ff, rsp_in;

   logic              free_hit, match_hit, sid_ok;
   logic [IDX_W-1:0]  free_idx, match_idx, sid_idx, wr_idx;
   logic [WIDE_W-1:0] sid_wide, free_wide, match_wide;

   logic              server_we, peer_we, conn_we;
   logic [PORT_W-1:0] peer_wdata;
   logic [1:0]        conn_wdata;

   // Lowest free entry and lowest valid entry whose server port matches.
   always_comb begin
      free_hit  = 1'b0;
      free_idx  = '0;
      match_hit = 1'b0;
      match_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_hit = 1'b1;
            free_idx = IDX_W'(i);
         end
         if (valid_ff[i] && (server_ff[i] == item_ff.seg_dest_port)) begin
            match_hit = 1'b1;
            match_idx = IDX_W'(i);
         end
      end
   end

   assign sid_wide = WIDE_W'(item_ff.socket_id);
   assign sid_idx  = sid_wide[IDX_W-1:0];
   assign sid_ok   = (sid_wide < WIDE_W'(ENTRIES)) && valid_ff[sid_idx];

   assign free_wide  = WIDE_W'(free_idx_ff);
   assign match_wide = WIDE_W'(match_idx_ff);

   always_comb begin
      rsp_in     = '0;
      valid_in   = valid_ff;
      wr_idx     = '0;
      server_we  = 1'b0;
      peer_we    = 1'b0;
      conn_we    = 1'b0;
      peer_wdata = '0;
      conn_wdata = CONN_CLOSED;
      case (item_ff.kind)
         KIND_OPEN: begin
            if (free_hit_ff) begin
               wr_idx               = free_idx_ff;
               valid_in[free_idx_ff] = 1'b1;
               server_we            = 1'b1;
               peer_we              = 1'b1;
               conn_we              = 1'b1;
               rsp_in.result_socket = free_wide[SOCK_W-1:0];
               rsp_in.entry_state   = CONN_CLOSED;
            end else begin
               rsp_in.status = STAT_FULL;
            end
         end
         KIND_LISTEN: begin
            rsp_in.result_socket = item_ff.socket_id;
            if (sid_ok_ff) begin
               wr_idx             = sid_idx;
               conn_we            = 1'b1;
               conn_wdata         = CONN_LISTEN;
               rsp_in.entry_state = CONN_LISTEN;
            end else begin
               rsp_in.status = STAT_BAD_SOCK;
            end
         end
         KIND_CLOSE: begin
            rsp_in.result_socket = item_ff.socket_id;
            if (sid_ok_ff) begin
               wr_idx            = sid_idx;
               valid_in[sid_idx] = 1'b0;
               conn_we           = 1'b1;
               conn_wdata        = CONN_CLOSED;
            end else begin
               rsp_in.status = STAT_BAD_SOCK;
            end
         end
         KIND_SEGMENT: begin
            if (match_hit_ff) begin
               wr_idx                 = match_idx_ff;
               rsp_in.result_socket   = match_wide[SOCK_W-1:0];
               rsp_in.entry_state     = conn_rd_ff;
               rsp_in.reply_src_port  = server_rd_ff;
               rsp_in.reply_dest_port = peer_rd_ff;
               if ((conn_rd_ff == CONN_LISTEN) && (item_ff.seg_type == SEG_SYN)) begin
                  peer_we                = 1'b1;
                  peer_wdata             = item_ff.seg_src_port;
                  conn_we                = 1'b1;
                  conn_wdata             = CONN_ESTAB;
                  rsp_in.entry_state     = CONN_ESTAB;
                  rsp_in.reply_valid     = 1'b1;
                  rsp_in.reply_type      = REPLY_SYNACK;
                  rsp_in.reply_dest_port = item_ff.seg_src_port;
               end else if ((conn_rd_ff == CONN_ESTAB) && (item_ff.seg_type == SEG_SYN)) begin
                  rsp_in.reply_valid = 1'b1;
                  rsp_in.reply_type  = REPLY_SYNACK;
               end else if ((conn_rd_ff == CONN_ESTAB) && (item_ff.seg_type == SEG_FIN)) begin
                  conn_we            = 1'b1;
                  conn_wdata         = CONN_CLOSE_WAIT;
                  rsp_in.entry_state = CONN_CLOSE_WAIT;
                  rsp_in.reply_valid = 1'b1;
                  rsp_in.reply_type  = REPLY_FINACK;
               end else if ((conn_rd_ff == CONN_CLOSE_WAIT) &&
                            (item_ff.seg_type == SEG_FIN)) begin
                  rsp_in.reply_valid = 1'b1;
                  rsp_in.reply_type  = REPLY_FINACK;
               end
               // Dropped segments carry no reply header.
               if (!rsp_in.reply_valid) begin
                  rsp_in.reply_src_port  = '0;
                  rsp_in.reply_dest_port = '0;
               end
            end else begin
               rsp_in.status = STAT_NO_MATCH;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.exec) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.look) begin
         free_hit_ff  <= free_hit;
         free_idx_ff  <= free_idx;
         match_hit_ff <= match_hit;
         match_idx_ff <= match_idx;
         sid_ok_ff    <= sid_ok;
         server_rd_ff <= server_ff[match_idx];
         peer_rd_ff   <= peer_ff[match_idx];
         conn_rd_ff   <= conn_ff[match_idx];
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
         if (server_we) server_ff[wr_idx] <= item_ff.open_port;
         if (peer_we)   peer_ff[wr_idx]   <= peer_wdata;
         if (conn_we)   conn_ff[wr_idx]   <= conn_wdata;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

[src/transport_server_conn_table.sv]
`default_nettype none
`include "transport_server_conn_table_assert.svh"
// ----------------------------------------------------------------------------
// Transport server connection table
// Socket table with open, listen, close and segment handling for a server.
// ----------------------------------------------------------------------------
// Each request word is one operation on a table of ENTRIES server connection
// entries and gives exactly one response word. An open takes the lowest free
// entry, a listen or close addresses an entry by socket id, and an arriving
// segment header is matched on its destination port against the lowest valid
// entry, which may answer with a SYNACK or FINACK header and move the entry's
// state. The block works on one word at a time in three steps: the request is
// captured at the edge that accepts it, the next cycle does the table search
// and the read of the matched entry, and the execute step then applies the
// update and loads the response register. A new word is accepted only once
// the previous word has left the execute step. A stalled response holds the
// execute step until the response register frees up. No clearing pass
// follows reset; the table is empty at once.
// ----------------------------------------------------------------------------
module transport_server_conn_table import tsct_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   cmd_type cmd;

   // The controller steps each word through capture, lookup and execute.
   tsct_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // The datapath owns the table, the search logic and the response register.
   tsct_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // Once a word is taken, the block stays busy while it is worked on.
   `TSCT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
      "accepted word did not make the block busy")

   // A new response only comes out of the execute step, when the block was busy.
   `TSCT_ASSERT_SAME(a_rsp_from_exec, $rose(rsp_valid), $past(req_stall),
      "response appeared without a word in flight")

   // Any error response carries no reply and reports a closed entry.
   `TSCT_ASSERT_SAME(a_error_clean, rsp_valid && (rsp_data.status != STAT_OK),
      !rsp_data.reply_valid && (rsp_data.entry_state == CONN_CLOSED),
      "error response carries reply or state")

   // Reply fields are zero whenever no reply is called for.
   `TSCT_ASSERT_SAME(a_reply_zero, rsp_valid && !rsp_data.reply_valid,
      (rsp_data.reply_type == REPLY_SYNACK) && (rsp_data.reply_src_port == '0) &&
      (rsp_data.reply_dest_port == '0),
      "reply fields set without a reply")

endmodule
`default_nettype wire
